// File: design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master register controller.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int REG_WORDS_DEFAULT = 256;

  // Byte offsets of the registers with side effects.
  localparam logic [9:0] OFF_CR1  = 10'h000;
  localparam logic [9:0] OFF_CR2  = 10'h004;
  localparam logic [9:0] OFF_ICR  = 10'h01C;
  localparam logic [9:0] OFF_RXDR = 10'h024;
  localparam logic [9:0] OFF_TXDR = 10'h028;

  // Word indexes of the registers kept in flip-flops.
  localparam logic [7:0] W_CR1  = 8'd0;
  localparam logic [7:0] W_CR2  = 8'd1;
  localparam logic [7:0] W_ISR  = 8'd6;
  localparam logic [7:0] W_TXDR = 8'd10;

  // CR1 and CR2 bits.
  localparam int B_PE      = 0;
  localparam int B_RDWRN   = 10;
  localparam int B_START   = 13;
  localparam int B_STOP    = 14;
  localparam int B_RELOAD  = 24;
  localparam int B_AUTOEND = 25;
  localparam int NB_LSB    = 16;
  localparam logic [31:0] M_START_STOP = 32'h0000_6000;

  // ISR flags.
  localparam logic [31:0] F_TXE  = 32'h0000_0001;
  localparam logic [31:0] F_TXIS = 32'h0000_0002;
  localparam logic [31:0] F_RXNE = 32'h0000_0004;
  localparam logic [31:0] F_NACK = 32'h0000_0010;
  localparam logic [31:0] F_STOP = 32'h0000_0020;
  localparam logic [31:0] F_TC   = 32'h0000_0040;
  localparam logic [31:0] F_TCR  = 32'h0000_0080;
  localparam logic [31:0] F_BUSY = 32'h0000_8000;

  // Transfer kinds.
  localparam logic [1:0] XF_NONE  = 2'd0;
  localparam logic [1:0] XF_READ  = 2'd1;
  localparam logic [1:0] XF_WRITE = 2'd2;

  // Access classes decided at the front.
  typedef logic [2:0] cls_t;
  localparam cls_t CLS_BAD  = 3'd0;
  localparam cls_t CLS_PRD  = 3'd1;
  localparam cls_t CLS_RXDR = 3'd2;
  localparam cls_t CLS_CR2  = 3'd3;
  localparam cls_t CLS_TXDR = 3'd4;
  localparam cls_t CLS_ICR  = 3'd5;
  localparam cls_t CLS_CR1  = 3'd6;
  localparam cls_t CLS_PWR  = 3'd7;

  typedef struct packed {
    logic        command;
    logic [9:0]  offset;
    logic [2:0]  access_size;
    logic [31:0] write_data;
    logic        target_ack;
    logic [7:0]  target_byte;
  } in_item_t;

  typedef struct packed {
    logic        access_ok;
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [1:0]  transfer_kind;
    logic [6:0]  transfer_addr;
    logic [7:0]  transfer_count;
  } out_item_t;

  typedef struct packed {
    cls_t        cls;
    logic [9:0]  offset;
    logic [2:0]  access_size;
    logic [31:0] write_data;
    logic        target_ack;
    logic [7:0]  target_byte;
  } op_t;

endpackage

// File: design/i2cm_req_if.sv
// ----------------------------------------------------------------------------
// i2cm_req_if
// Access channel into the controller.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
  import i2cm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// File: design/i2cm_rsp_if.sv
// ----------------------------------------------------------------------------
// i2cm_rsp_if
// Result channel out of the controller.
// ----------------------------------------------------------------------------
interface i2cm_rsp_if;
  import i2cm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// File: design/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Checks the access against the window and classifies it.
// ----------------------------------------------------------------------------
module i2cm_front #(
  parameter int REG_WORDS = i2cm_pkg::REG_WORDS_DEFAULT
) (
  i2cm_req_if.sink         req,
  input  logic             full,
  output logic             push,
  output i2cm_pkg::op_t    op
);
  import i2cm_pkg::*;

  localparam logic [11:0] WIN_BYTES = 12'(REG_WORDS * 4);

  logic [11:0] span;
  logic        ok;
  cls_t        cls;

  assign span = {2'b00, req.item.offset} + {9'b0, req.item.access_size};
  assign ok   = (req.item.access_size != 3'd0) && (req.item.access_size <= 3'd4) &&
                (span <= WIN_BYTES);

  always_comb begin
    if (!ok) begin
      cls = CLS_BAD;
    end else if (!req.item.command) begin
      cls = (req.item.offset == OFF_RXDR) ? CLS_RXDR : CLS_PRD;
    end else if (req.item.offset == OFF_CR2 && req.item.access_size == 3'd4) begin
      cls = CLS_CR2;
    end else if (req.item.offset == OFF_TXDR) begin
      cls = CLS_TXDR;
    end else if (req.item.offset == OFF_ICR && req.item.access_size == 3'd4) begin
      cls = CLS_ICR;
    end else if (req.item.offset == OFF_CR1 && req.item.access_size == 3'd4) begin
      cls = CLS_CR1;
    end else begin
      cls = CLS_PWR;
    end
  end

  assign req.ready = !full;
  assign push      = req.valid && !full;

  assign op.cls         = cls;
  assign op.offset      = req.item.offset;
  assign op.access_size = req.item.access_size;
  assign op.write_data  = req.item.write_data;
  assign op.target_ack  = req.item.target_ack;
  assign op.target_byte = req.item.target_byte;
endmodule

// File: design/i2cm_queue.sv
// ----------------------------------------------------------------------------
// i2cm_queue
// Two-entry queue of classified accesses between front and back.
// ----------------------------------------------------------------------------
module i2cm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  i2cm_pkg::op_t    din,
  output logic             full,
  input  logic             pop,
  output i2cm_pkg::op_t    dout,
  output logic             empty
);
  import i2cm_pkg::*;

  op_t        ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  // Held full during reset so that no item is taken then.
  assign full  = cnt[1] || rst;
  assign empty = (cnt == 2'd0);
  assign dout  = ent[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: design/i2cm_back.sv
// ----------------------------------------------------------------------------
// i2cm_back
// Executes accesses: register side effects, byte-lane storage and results.
// ----------------------------------------------------------------------------
module i2cm_back #(
  parameter int REG_WORDS = i2cm_pkg::REG_WORDS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  i2cm_pkg::op_t    op,
  input  logic             empty,
  output logic             pop,
  i2cm_rsp_if.source       rsp
);
  import i2cm_pkg::*;

  localparam int AW = $clog2(REG_WORDS);
  localparam logic [AW-1:0] LAST_WORD = AW'(REG_WORDS - 1);

  function automatic logic [31:0] isr_idle(input logic [31:0] isr_in);
    return (isr_in & ~(F_BUSY | F_TXIS | F_RXNE)) | F_TXE;
  endfunction

  function automatic logic [31:0] isr_complete(input logic [31:0] isr_in,
                                               input logic reload, input logic ae);
    logic [31:0] v;
    v = (isr_in & ~(F_TXIS | F_RXNE)) | F_TXE;
    if (reload) begin
      v = v | F_TCR;
    end else if (ae) begin
      v = (v | F_STOP) & ~F_BUSY;
    end else begin
      v = v | F_TC;
    end
    return v;
  endfunction

  logic        fire;
  logic [31:0] wd;
  logic [7:0]  nb;

  // Registers with side effects live in flip-flops.
  logic [31:0] cr1, cr2, isr, txdr;
  logic [31:0] cr1_next, cr2_next, isr_next, txdr_next;
  logic [6:0]  taddr, taddr_next;
  logic        reading, reading_next;
  logic        auto_end, auto_end_next;
  logic        active, active_next;
  logic [7:0]  exp_cnt, exp_next;
  logic [7:0]  bpos, bpos_next;
  logic [7:0]  rlen, rlen_next;

  logic [1:0]      kind;
  logic [6:0]      xaddr;
  logic [7:0]      xcnt;
  logic            txv;
  logic [7:0]      txb;
  logic [3:0]      sel;
  logic [3:0][7:0] fbyte;
  logic [7:0]      rx_byte;
  logic [9:0]      lane_a;

  // Storage banks, one per byte lane.
  logic [3:0][7:0] bank_q;
  logic            clearing;
  logic [AW-1:0]   clr_addr;

  // Result register.
  logic            o_valid;
  logic            o_ok;
  logic            o_txv;
  logic [7:0]      o_txb;
  logic [1:0]      o_kind;
  logic [6:0]      o_addr;
  logic [7:0]      o_cnt;
  logic [1:0]      o_off_lo;
  logic [2:0]      o_size;
  logic [3:0]      o_sel;
  logic [3:0][7:0] o_fbyte;

  assign fire = !empty && !clearing && (!o_valid || rsp.ready);
  assign pop  = fire;
  assign wd   = op.write_data;
  assign nb   = wd[NB_LSB +: 8];

  // After reset every storage word is written with zero, one word per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_WORD) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]    mem [REG_WORDS];
    logic [1:0]    lane;
    logic [9:0]    a;
    logic [AW-1:0] waddr;
    logic          we;

    assign lane  = 2'(b) - op.offset[1:0];
    assign a     = op.offset + {8'b0, lane};
    assign waddr = a[AW+1:2];
    assign we    = fire && (op.cls == CLS_PWR) && ({1'b0, lane} < op.access_size);

    always_ff @(posedge clk) begin
      if (clearing) begin
        mem[clr_addr] <= 8'd0;
      end else if (we) begin
        mem[waddr] <= wd[{lane, 3'b000} +: 8];
      end
      if (fire) begin
        bank_q[b] <= mem[waddr];
      end
    end
  end

  always_comb begin
    cr1_next      = cr1;
    cr2_next      = cr2;
    isr_next      = isr;
    txdr_next     = txdr;
    taddr_next    = taddr;
    reading_next  = reading;
    auto_end_next = auto_end;
    active_next   = active;
    exp_next      = exp_cnt;
    bpos_next     = bpos;
    rlen_next     = rlen;
    kind          = XF_NONE;
    xaddr         = 7'd0;
    xcnt          = 8'd0;
    txv           = 1'b0;
    txb           = 8'd0;
    sel           = 4'hf;
    fbyte         = '0;
    rx_byte       = 8'hff;
    lane_a        = 10'd0;

    unique case (op.cls)
      CLS_RXDR: begin
        if (bpos < rlen) begin
          rx_byte   = op.target_byte;
          bpos_next = bpos + 8'd1;
        end
        if (bpos_next < rlen) begin
          isr_next = isr_next | F_RXNE;
        end else begin
          isr_next = isr_next & ~F_RXNE;
          if (active && reading) begin
            isr_next = isr_complete(isr_next, cr2[B_RELOAD], auto_end);
            if (!cr2[B_RELOAD] && auto_end) begin
              active_next = 1'b0;
            end
          end
        end
        fbyte[0] = rx_byte;
      end

      CLS_PRD: begin
        // Lanes that fall on flip-flop registers bypass the banks.
        for (int i = 0; i < 4; i++) begin
          lane_a = op.offset + 10'(i);
          sel[i] = 1'b1;
          if (lane_a[9:2] == W_CR1) begin
            fbyte[i] = cr1[{lane_a[1:0], 3'b000} +: 8];
          end else if (lane_a[9:2] == W_CR2) begin
            fbyte[i] = cr2[{lane_a[1:0], 3'b000} +: 8];
          end else if (lane_a[9:2] == W_ISR) begin
            fbyte[i] = isr[{lane_a[1:0], 3'b000} +: 8];
          end else if (lane_a[9:2] == W_TXDR) begin
            fbyte[i] = txdr[{lane_a[1:0], 3'b000} +: 8];
          end else begin
            sel[i] = 1'b0;
          end
        end
      end

      CLS_PWR: begin
        for (int i = 0; i < 4; i++) begin
          lane_a = op.offset + 10'(i);
          if (3'(i) < op.access_size) begin
            if (lane_a[9:2] == W_CR1) begin
              cr1_next[{lane_a[1:0], 3'b000} +: 8] = wd[8*i +: 8];
            end else if (lane_a[9:2] == W_CR2) begin
              cr2_next[{lane_a[1:0], 3'b000} +: 8] = wd[8*i +: 8];
            end else if (lane_a[9:2] == W_ISR) begin
              isr_next[{lane_a[1:0], 3'b000} +: 8] = wd[8*i +: 8];
            end else if (lane_a[9:2] == W_TXDR) begin
              txdr_next[{lane_a[1:0], 3'b000} +: 8] = wd[8*i +: 8];
            end
          end
        end
      end

      CLS_CR2: begin
        cr2_next = wd & ~M_START_STOP;
        if (wd[B_START]) begin
          isr_next      = isr_next & ~(F_NACK | F_STOP | F_TC | F_TCR | F_TXIS | F_RXNE);
          taddr_next    = wd[7:1];
          reading_next  = wd[B_RDWRN];
          auto_end_next = wd[B_AUTOEND];
          exp_next      = nb;
          bpos_next     = 8'd0;
          rlen_next     = 8'd0;
          active_next   = 1'b1;
          isr_next      = isr_next | F_BUSY | F_TXE;
          if (!cr1[B_PE]) begin
            isr_next    = isr_idle(isr_next | F_NACK);
            active_next = 1'b0;
          end else if (wd[B_RDWRN]) begin
            if (nb == 8'd0) begin
              isr_next = isr_complete(isr_next, wd[B_RELOAD], wd[B_AUTOEND]);
              if (!wd[B_RELOAD] && wd[B_AUTOEND]) begin
                active_next = 1'b0;
              end
            end else begin
              kind  = XF_READ;
              xaddr = wd[7:1];
              xcnt  = nb;
              if (!op.target_ack) begin
                isr_next    = isr_idle(isr_next | F_NACK | F_STOP);
                active_next = 1'b0;
              end else begin
                rlen_next = nb;
                isr_next  = isr_next | F_RXNE;
              end
            end
          end else begin
            if (nb == 8'd0) begin
              kind  = XF_WRITE;
              xaddr = wd[7:1];
              if (!op.target_ack) begin
                isr_next = isr_next | F_NACK;
              end
              isr_next = isr_complete(isr_next, wd[B_RELOAD], wd[B_AUTOEND]);
              if (!wd[B_RELOAD] && wd[B_AUTOEND]) begin
                active_next = 1'b0;
              end
            end else begin
              isr_next = isr_next | F_TXIS;
            end
          end
        end
        if (wd[B_STOP]) begin
          isr_next    = isr_idle(isr_next | F_STOP);
          active_next = 1'b0;
        end
      end

      CLS_TXDR: begin
        txdr_next = {24'b0, wd[7:0]};
        if (active && !reading) begin
          txv = 1'b1;
          txb = wd[7:0];
          if (bpos != 8'hff) begin
            bpos_next = bpos + 8'd1;
          end
          if (bpos_next >= exp_cnt) begin
            isr_next = isr_next & ~F_TXIS;
            kind     = XF_WRITE;
            xaddr    = taddr;
            xcnt     = exp_cnt;
            if (!op.target_ack) begin
              isr_next    = isr_idle(isr_next | F_NACK | F_STOP);
              active_next = 1'b0;
            end else begin
              isr_next = isr_complete(isr_next, cr2[B_RELOAD], auto_end);
              if (!cr2[B_RELOAD] && auto_end) begin
                active_next = 1'b0;
              end
            end
          end else begin
            isr_next = isr_next | F_TXIS | F_TXE;
          end
        end
      end

      CLS_ICR: begin
        isr_next = isr & ~(wd & (F_NACK | F_STOP));
      end

      CLS_CR1: begin
        cr1_next = wd;
        if (!wd[B_PE]) begin
          isr_next    = isr_idle(isr_next);
          active_next = 1'b0;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cr1      <= '0;
      cr2      <= '0;
      isr      <= F_TXE;
      txdr     <= '0;
      taddr    <= '0;
      reading  <= 1'b0;
      auto_end <= 1'b0;
      active   <= 1'b0;
      exp_cnt  <= '0;
      bpos     <= '0;
      rlen     <= '0;
      o_valid  <= 1'b0;
    end else begin
      if (fire) begin
        cr1      <= cr1_next;
        cr2      <= cr2_next;
        isr      <= isr_next;
        txdr     <= txdr_next;
        taddr    <= taddr_next;
        reading  <= reading_next;
        auto_end <= auto_end_next;
        active   <= active_next;
        exp_cnt  <= exp_next;
        bpos     <= bpos_next;
        rlen     <= rlen_next;
        o_valid  <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_ok     <= (op.cls != CLS_BAD);
      o_txv    <= txv;
      o_txb    <= txb;
      o_kind   <= kind;
      o_addr   <= xaddr;
      o_cnt    <= xcnt;
      o_off_lo <= op.offset[1:0];
      o_size   <= op.access_size;
      o_sel    <= sel;
      o_fbyte  <= fbyte;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (3'(i) >= o_size) begin
        rsp.item.read_data[8*i +: 8] = 8'd0;
      end else if (o_sel[i]) begin
        rsp.item.read_data[8*i +: 8] = o_fbyte[i];
      end else begin
        rsp.item.read_data[8*i +: 8] = bank_q[2'(o_off_lo + 2'(i))];
      end
    end
  end

  assign rsp.valid               = o_valid;
  assign rsp.item.access_ok      = o_ok;
  assign rsp.item.tx_valid       = o_txv;
  assign rsp.item.tx_byte        = o_txb;
  assign rsp.item.transfer_kind  = o_kind;
  assign rsp.item.transfer_addr  = o_addr;
  assign rsp.item.transfer_count = o_cnt;
endmodule

// File: design/i2c_master_register_controller_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_register_controller_unit
// Transaction-level I2C master behind a byte-addressed register window.
// ----------------------------------------------------------------------------
// The block takes one register access per clock cycle unless the queue or the
// result side holds it off, and returns one result item per access, passed
// from the queue entry through the execute stage into the result register.
// Throughput is set by the execute stage, which applies all of an access's
// register and transfer side effects as it takes the access; a two-entry queue
// between the classifying front and the execute stage lets either side stall
// alone. Plain storage sits in four byte-lane memories that a clearing pass
// zeroes after reset; meanwhile the input takes at most two items, then waits.
module i2c_master_register_controller_unit #(
  parameter int REG_WORDS = i2cm_pkg::REG_WORDS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  i2cm_req_if.sink   req,
  i2cm_rsp_if.source rsp
);
  import i2cm_pkg::*;

  op_t  f_op;
  op_t  q_op;
  logic f_push;
  logic q_full;
  logic q_empty;
  logic b_pop;

  i2cm_front #(.REG_WORDS(REG_WORDS)) u_front (
    .req  (req),
    .full (q_full),
    .push (f_push),
    .op   (f_op)
  );

  i2cm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_op),
    .full  (q_full),
    .pop   (b_pop),
    .dout  (q_op),
    .empty (q_empty)
  );

  i2cm_back #(.REG_WORDS(REG_WORDS)) u_back (
    .clk   (clk),
    .rst   (rst),
    .op    (q_op),
    .empty (q_empty),
    .pop   (b_pop),
    .rsp   (rsp)
  );
endmodule

// File: design/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the result channel of the controller.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input i2cm_pkg::out_item_t rsp_item
);
  import i2cm_pkg::*;

  // A rejected access reports nothing.
  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_item.access_ok |->
      rsp_item.read_data == 32'd0 && rsp_item.transfer_kind == XF_NONE &&
      !rsp_item.tx_valid)
    else $error("rejected access carries a result");

  // Address and count are zero unless a transfer is reported.
  a_no_xfer_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.transfer_kind == XF_NONE |->
      rsp_item.transfer_addr == 7'd0 && rsp_item.transfer_count == 8'd0)
    else $error("transfer fields set without a transfer");

  // A queued transmit byte always comes with its write transfer or none.
  a_tx_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.tx_valid |->
      rsp_item.transfer_kind != XF_READ)
    else $error("transmit byte alongside a read transfer");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !rsp_valid)
    else $error("result valid out of reset");
endmodule

bind i2c_master_register_controller_unit i2cm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_item  (rsp.item)
);
